// ----- sv/nfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// nfpa_pkg
// Shared types and constants of the NAND flash page array core.
// ----------------------------------------------------------------------------
`default_nettype none

package nfpa_pkg;

  localparam int OPCODE_W  = 2;
  localparam int BANK_W    = 2;
  localparam int BLOCK_W   = 8;
  localparam int PAGE_W    = 6;
  localparam int WORD_W    = 32;
  localparam int SPARE_W   = 8;
  localparam int STATUS_W  = 3;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int BANKS_W    = 3;
  localparam int BLOCKS_W   = 9;
  localparam int PAGES_W    = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_BANKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES  = 2'd2;

  localparam logic [BANKS_W-1:0]  BANKS_RST  = 3'd4;
  localparam logic [BLOCKS_W-1:0] BLOCKS_RST = 9'd256;
  localparam logic [PAGES_W-1:0]  PAGES_RST  = 7'd64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_READ     = 2'd0,
    OP_PROGRAM  = 2'd1,
    OP_ERASE    = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_OVERWRITE = 3'd2,
    ST_ORDER     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ----- sv/nfpa_ram.sv -----
// ----------------------------------------------------------------------------
// nfpa_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/nand_flash_page_array_core.sv -----
// ----------------------------------------------------------------------------
// nand_flash_page_array_core
// Banked NAND flash array with in-order page programming and block erase.
// ----------------------------------------------------------------------------
// For each command the page bitmap row of the addressed block is read from
// a single-port RAM in the accept cycle and checked and written back in the
// execute state once the output register is free, so one command is in
// flight at a time. The result sits in an output register and a new command
// is taken while it waits. After reset the bitmap RAM is cleared one row per
// cycle; no command is taken until that pass ends, configuration writes are
// taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module nand_flash_page_array_core
  import nfpa_pkg::*;
#(
  parameter int MAX_BANKS  = 4,
  parameter int MAX_BLOCKS = 256,
  parameter int MAX_PAGES  = 64,
  parameter int DATA_BITS  = 32,
  parameter int SPARE_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // opcode[1:0], bank_index[3:2], block_index[11:4], page_index[17:12],
  // write_word[49:18], write_spare[57:50], zero fill
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // status[2:0], read_word[34:3], read_spare[42:35], zero fill
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROWS    = MAX_BANKS * MAX_BLOCKS;
  localparam int CELLS   = ROWS * MAX_PAGES;
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PAY_W   = DATA_BITS + SPARE_BITS;

  // configuration
  logic [BANKS_W-1:0]  banks_r;
  logic [BLOCKS_W-1:0] blocks_r;
  logic [PAGES_W-1:0]  pages_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      banks_r  <= BANKS_RST;
      blocks_r <= BLOCKS_RST;
      pages_r  <= PAGES_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BANKS) begin
        banks_r <= cfg_data[BANKS_W-1:0];
      end else if (cfg_index == CFG_BLOCKS) begin
        blocks_r <= cfg_data[BLOCKS_W-1:0];
      end else if (cfg_index == CFG_PAGES) begin
        pages_r <= cfg_data[PAGES_W-1:0];
      end
    end
  end

  // input unpacking
  logic [BANK_W-1:0]  in_bank;
  logic [BLOCK_W-1:0] in_block;
  logic [PAGE_W-1:0]  in_page;
  logic [ROW_AW-1:0]  in_row;
  logic [CELL_AW-1:0] in_cell;
  logic               in_beat;

  assign in_bank  = in_tdata[3:2];
  assign in_block = in_tdata[11:4];
  assign in_page  = in_tdata[17:12];
  assign in_row   = ROW_AW'(int'(in_bank) * MAX_BLOCKS + int'(in_block));
  assign in_cell  = CELL_AW'((int'(in_bank) * MAX_BLOCKS + int'(in_block)) * MAX_PAGES
                             + int'(in_page));
  assign in_beat  = in_tvalid && in_tready;

  // state
  state_t               state_r, state_nxt;
  logic [ROW_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  op_t                  op_r;
  logic [BANK_W-1:0]    bank_r;
  logic [BLOCK_W-1:0]   block_r;
  logic [PAGE_W-1:0]    page_r;
  logic [WORD_W-1:0]    wword_r;
  logic [SPARE_W-1:0]   wspare_r;
  logic [ROW_AW-1:0]    row_r;
  logic [CELL_AW-1:0]   cell_r;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [WORD_W-1:0]    out_word_r, out_word_nxt;
  logic [SPARE_W-1:0]   out_spare_r, out_spare_nxt;

  // memories
  logic                 map_en, map_we;
  logic [ROW_AW-1:0]    map_addr;
  logic [MAX_PAGES-1:0] map_wdata, map_rdata;
  logic                 pay_en, pay_we;
  logic [CELL_AW-1:0]   pay_addr;
  logic [PAY_W-1:0]     pay_wdata, pay_rdata;

  nfpa_ram #(
    .WIDTH (MAX_PAGES),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk   (clk),
    .en    (map_en),
    .we    (map_we),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  nfpa_ram #(
    .WIDTH (PAY_W),
    .DEPTH (CELLS)
  ) u_pay_ram (
    .clk   (clk),
    .en    (pay_en),
    .we    (pay_we),
    .addr  (pay_addr),
    .wdata (pay_wdata),
    .rdata (pay_rdata)
  );

  // page masks of the current command
  logic [MAX_PAGES-1:0] used_m, bit_m, below_m;
  logic                 addr_ok, page_ok, hit, done;
  logic [63:0]          wword_x, wspare_x, rword_x, rspare_x;

  always_comb begin
    for (int p = 0; p < MAX_PAGES; p++) begin
      used_m[p]  = p < int'(pages_r);
      bit_m[p]   = p == int'(page_r);
      below_m[p] = p < int'(page_r);
    end
  end

  assign addr_ok = (int'(bank_r) < int'(banks_r)) && (int'(bank_r) < MAX_BANKS)
                && (int'(block_r) < int'(blocks_r)) && (int'(block_r) < MAX_BLOCKS);
  assign page_ok = (int'(page_r) < int'(pages_r)) && (int'(page_r) < MAX_PAGES);
  assign hit     = |(map_rdata & bit_m);
  assign done    = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign wword_x   = 64'(wword_r);
  assign wspare_x  = 64'(wspare_r);
  assign pay_wdata = {wspare_x[SPARE_BITS-1:0], wword_x[DATA_BITS-1:0]};
  assign rword_x   = 64'(pay_rdata[DATA_BITS-1:0]);
  assign rspare_x  = 64'(pay_rdata[PAY_W-1:DATA_BITS]);

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_spare_nxt  = out_spare_r;
    map_en         = 1'b0;
    map_we         = 1'b0;
    map_addr       = row_r;
    map_wdata      = '0;
    pay_en         = 1'b0;
    pay_we         = 1'b0;
    pay_addr       = cell_r;

    unique case (state_r)
      S_CLEAR: begin
        map_en   = 1'b1;
        map_we   = 1'b1;
        map_addr = clr_cnt_r;
        if (clr_cnt_r == ROW_AW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        map_addr = in_row;
        pay_addr = in_cell;
        if (in_beat) begin
          map_en    = 1'b1;
          pay_en    = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_word_nxt   = '0;
          out_spare_nxt  = '0;
          if (!addr_ok || op_r == OP_RESERVED || (op_r != OP_ERASE && !page_ok)) begin
            out_status_nxt = ST_INVALID;
          end else begin
            unique case (op_r)
              OP_READ: begin
                if (!hit) begin
                  out_status_nxt = ST_EMPTY;
                end else begin
                  out_word_nxt  = rword_x[WORD_W-1:0];
                  out_spare_nxt = rspare_x[SPARE_W-1:0];
                end
              end
              OP_PROGRAM: begin
                if (hit) begin
                  out_status_nxt = ST_OVERWRITE;
                end else if ((map_rdata & below_m) != below_m) begin
                  out_status_nxt = ST_ORDER;
                end else begin
                  map_en    = 1'b1;
                  map_we    = 1'b1;
                  map_wdata = map_rdata | bit_m;
                  pay_en    = 1'b1;
                  pay_we    = 1'b1;
                end
              end
              OP_ERASE: begin
                if ((map_rdata & used_m) == '0) begin
                  out_status_nxt = ST_EMPTY;
                end else begin
                  map_en    = 1'b1;
                  map_we    = 1'b1;
                  map_wdata = map_rdata & ~used_m;
                end
              end
              OP_RESERVED: begin
                out_status_nxt = ST_INVALID;
              end
              default: begin
                out_status_nxt = ST_INVALID;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r     <= op_t'(in_tdata[1:0]);
      bank_r   <= in_bank;
      block_r  <= in_block;
      page_r   <= in_page;
      wword_r  <= in_tdata[49:18];
      wspare_r <= in_tdata[57:50];
      row_r    <= in_row;
      cell_r   <= in_cell;
    end
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_spare_r  <= out_spare_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_spare_r, out_word_r, out_status_r};

endmodule

`default_nettype wire

// ----- tb/tb_nand_flash_page_array_core.sv -----
// ----------------------------------------------------------------------------
// tb_nand_flash_page_array_core
// Self-checking testbench of the NAND flash page array core.
// ----------------------------------------------------------------------------
// Commands go in as stream beats and are scored against a model of the page
// bitmap and payload kept here. Directed tests cover zero and out-of-range
// limits, program ordering, overwrite, empty reads and erases, and erase
// with a reduced page count. Random traffic follows, mostly in-order
// programs, reads and erases on a few blocks, under several limit settings
// and with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nand_flash_page_array_core;
  import nfpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_BANKS  = 4;
  localparam int N_BLOCKS = 256;
  localparam int N_PAGES  = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    op_t                 op;
    logic [BANK_W-1:0]   bank;
    logic [BLOCK_W-1:0]  blk;
    logic [PAGE_W-1:0]   page;
    logic [WORD_W-1:0]   word;
    logic [SPARE_W-1:0]  spare;
  } flash_cmd_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   word;
    logic [SPARE_W-1:0]  spare;
  } flash_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BANKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nand_flash_page_array_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // model state
  bit [63:0]          page_map  [N_BANKS*N_BLOCKS];
  bit [WORD_W-1:0]    data_mem  [N_BANKS*N_BLOCKS*N_PAGES];
  bit [SPARE_W-1:0]   spare_mem [N_BANKS*N_BLOCKS*N_PAGES];
  bit [BANKS_W-1:0]   banks_reg  = BANKS_RST;
  bit [BLOCKS_W-1:0]  blocks_reg = BLOCKS_RST;
  bit [PAGES_W-1:0]   pages_reg  = PAGES_RST;

  flash_rsp_t replies_due[$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         cycles = 0;

  function automatic int banks_used();
    return (banks_reg > N_BANKS) ? N_BANKS : int'(banks_reg);
  endfunction

  function automatic int blocks_used();
    return (blocks_reg > N_BLOCKS) ? N_BLOCKS : int'(blocks_reg);
  endfunction

  function automatic int pages_used();
    return (pages_reg > N_PAGES) ? N_PAGES : int'(pages_reg);
  endfunction

  function automatic bit [63:0] low_bits(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic flash_rsp_t apply_flash_cmd(flash_cmd_t c);
    flash_rsp_t r;
    int         row;
    int         cell_idx;
    bit [63:0]  bits;
    bit [63:0]  used;
    bit [63:0]  below;
    r.status = ST_OK;
    r.word   = '0;
    r.spare  = '0;
    if (c.op == OP_RESERVED || c.bank >= banks_used() || c.blk >= blocks_used() ||
        (c.op != OP_ERASE && c.page >= pages_used())) begin
      r.status = ST_INVALID;
    end else begin
      row      = c.bank * N_BLOCKS + c.blk;
      cell_idx = row * N_PAGES + c.page;
      bits     = page_map[row];
      case (c.op)
        OP_ERASE: begin
          used = low_bits(pages_used());
          if ((bits & used) == '0) r.status = ST_EMPTY;
          else page_map[row] = bits & ~used;
        end
        OP_READ: begin
          if (!bits[c.page]) begin
            r.status = ST_EMPTY;
          end else begin
            r.word  = data_mem[cell_idx];
            r.spare = spare_mem[cell_idx];
          end
        end
        default: begin
          below = low_bits(c.page);
          if (bits[c.page]) begin
            r.status = ST_OVERWRITE;
          end else if ((bits & below) != below) begin
            r.status = ST_ORDER;
          end else begin
            page_map[row][c.page] = 1'b1;
            data_mem[cell_idx]  = c.word;
            spare_mem[cell_idx] = c.spare;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic flash_cmd_t make_cmd(op_t op, int bank, int blk, int page,
                                          logic [WORD_W-1:0] word,
                                          logic [SPARE_W-1:0] spare);
    flash_cmd_t c;
    c.op    = op;
    c.bank  = BANK_W'(bank);
    c.blk   = BLOCK_W'(blk);
    c.page  = PAGE_W'(page);
    c.word  = word;
    c.spare = spare;
    return c;
  endfunction

  task automatic send_cmd(flash_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, c.spare, c.word, c.page, c.blk, c.bank, c.op};
    do @(posedge clk); while (!in_tready);
    replies_due.push_back(apply_flash_cmd(c));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(int banks, int blocks, int pages);
    logic [CFG_IDX_W-1:0] idx [3];
    int                   val [3];
    idx = '{CFG_BANKS, CFG_BLOCKS, CFG_PAGES};
    val = '{banks, blocks, pages};
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= CFG_DATA_W'(val[i]);
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_BANKS:  banks_reg  = BANKS_W'(val[i]);
        CFG_BLOCKS: blocks_reg = BLOCKS_W'(val[i]);
        default:    pages_reg  = PAGES_W'(val[i]);
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_limits();
    set_limits(0, 256, 64);
    send_cmd(make_cmd(OP_READ, 0, 0, 0, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_ERASE, 0, 0, 0, $urandom(), 8'($urandom())));
    set_limits(4, 0, 64);
    send_cmd(make_cmd(OP_PROGRAM, 0, 0, 0, $urandom(), 8'($urandom())));
    set_limits(4, 256, 0);
    send_cmd(make_cmd(OP_READ, 1, 1, 0, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_PROGRAM, 1, 1, 0, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_ERASE, 1, 1, 0, $urandom(), 8'($urandom())));
    set_limits(3, 255, 63);
    send_cmd(make_cmd(OP_READ, 3, 0, 0, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_PROGRAM, 0, 255, 0, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_PROGRAM, 0, 0, 63, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_RESERVED, 0, 0, 0, $urandom(), 8'($urandom())));
  endtask

  task automatic test_program_order();
    set_limits(4, 256, 64);
    send_cmd(make_cmd(OP_PROGRAM, 3, 255, 0, '1, '1));
    send_cmd(make_cmd(OP_READ, 3, 255, 0, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_PROGRAM, 3, 255, 0, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_PROGRAM, 3, 255, 2, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_READ, 3, 255, 1, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_PROGRAM, 3, 255, 1, '0, '0));
    send_cmd(make_cmd(OP_READ, 3, 255, 1, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_ERASE, 3, 255, 63, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_READ, 3, 255, 0, $urandom(), 8'($urandom())));
  endtask

  // pages above the count in use survive an erase
  task automatic test_partial_erase();
    for (int p = 0; p < 4; p++)
      send_cmd(make_cmd(OP_PROGRAM, 1, 7, p, $urandom(), 8'($urandom())));
    set_limits(4, 256, 2);
    send_cmd(make_cmd(OP_ERASE, 1, 7, 0, $urandom(), 8'($urandom())));
    set_limits(4, 256, 64);
    send_cmd(make_cmd(OP_READ, 1, 7, 2, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_PROGRAM, 1, 7, 1, $urandom(), 8'($urandom())));
    send_cmd(make_cmd(OP_PROGRAM, 1, 7, 0, $urandom(), 8'($urandom())));
  endtask

  task automatic test_random_traffic();
    int lim [8][3];
    int nb;
    int nk;
    int np;
    int bank;
    int blk;
    int fill;
    int row;
    int kind;
    int page;
    op_t op;
    lim = '{'{4, 256, 64}, '{2, 6, 16}, '{7, 511, 127}, '{1, 3, 4},
            '{3, 200, 33}, '{4, 2, 8}, '{2, 256, 64}, '{4, 4, 1}};
    for (int ph = 0; ph < 8; ph++) begin
      set_limits(lim[ph][0], lim[ph][1], lim[ph][2]);
      send_idle_pct  = (ph % 4 == 1) ? 81 : (ph % 4 == 3) ? 33 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 81 : (ph % 4 == 3) ? 33 : 0;
      nb = banks_used();
      nk = blocks_used();
      np = pages_used();
      for (int n = 0; n < 230; n++) begin
        bank = (nb > 0) ? $urandom_range(nb - 1) : $urandom_range(3);
        case ($urandom_range(3))
          0:       blk = 0;
          1:       blk = (nk > 0) ? nk - 1 : 0;
          default: blk = (nk > 0) ? $urandom_range(((nk < 8) ? nk : 8) - 1) : 0;
        endcase
        row  = bank * N_BLOCKS + blk;
        fill = 0;
        while (fill < 64 && page_map[row][fill]) fill++;
        kind = $urandom_range(99);
        page = $urandom_range(63);
        if (kind < 45) begin
          op = OP_PROGRAM;
          if (fill < np) page = fill;
        end else if (kind < 75) begin
          op = OP_READ;
          if (fill > 0 && $urandom_range(3) != 0) page = $urandom_range(fill - 1);
        end else if (kind < 85) begin
          op = OP_ERASE;
        end else begin
          op   = op_t'(OPCODE_W'($urandom_range(3)));
          bank = $urandom_range(3);
          blk  = $urandom_range(255);
        end
        send_cmd(make_cmd(op, bank, blk, page, $urandom(), 8'($urandom())));
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // result scoreboard and receiver stalls
  always @(posedge clk) begin : rsp_check
    flash_rsp_t want;
    flash_rsp_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[2:0]);
      got.word   = out_tdata[34:3];
      got.spare  = out_tdata[42:35];
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual status %0d", $time, got.status);
      end else begin
        want = replies_due.pop_front();
        if (got.status != want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   got.status);
        end
        if (got.word != want.word) begin
          errors++;
          $display("%0t: read_word expected %h actual %h", $time, want.word, got.word);
        end
        if (got.spare != want.spare) begin
          errors++;
          $display("%0t: read_spare expected %h actual %h", $time, want.spare,
                   got.spare);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_limits();
    test_program_order();
    test_partial_erase();
    test_random_traffic();
    in_tvalid <= 1'b0;
    for (int i = 0; i < 20000 && replies_due.size() != 0; i++) @(posedge clk);
    errors += replies_due.size();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/nfpa_pkg.sv
sv/nfpa_ram.sv
sv/nand_flash_page_array_core.sv
tb/tb_nand_flash_page_array_core.sv
